// File: rtl/console_command_line_parser_assert.svh
// ----------------------------------------------------------------------------
// Console command line parser - assertion macros
// Shared property macros, clocked on i_clk and idle while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_COMMAND_LINE_PARSER_ASSERT_SVH
`define CONSOLE_COMMAND_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define CCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Types, verb table and helper functions of the console command line parser.
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int NUM_VERBS = 19;
    localparam int VERB_MAX_LEN = 13;

    localparam logic [4:0] CODE_NONE    = 5'd0;
    localparam logic [4:0] CODE_UNKNOWN = 5'd1;

    localparam logic [VERB_MAX_LEN*8-1:0] VERB_TEXT [NUM_VERBS] = '{
        "help", "?", "status", "getcanspeed", "setcanspeed", "getflowpin",
        "setflowpin", "getmetric", "setmetric", "getk", "setk", "reset",
        "getcapture", "setcapture", "getcanreset", "setcanreset",
        "getpulseguard", "setpulseguard", "debug"
    };

    localparam logic [3:0] VERB_LEN [NUM_VERBS] = '{
        4'd4, 4'd1, 4'd6, 4'd11, 4'd11, 4'd10, 4'd10, 4'd9, 4'd9, 4'd4,
        4'd4, 4'd5, 4'd10, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd5
    };

    localparam logic [4:0] VERB_CODE [NUM_VERBS] = '{
        5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
    };

    localparam logic [NUM_VERBS-1:0] ALL_VERBS = {NUM_VERBS{1'b1}};

    typedef struct packed {
        logic [7:0] lc;
        logic       is_end;
        logic       is_ws;
        logic       is_digit;
        logic       is_plus;
        logic       is_minus;
        logic [3:0] digit;
    } t_byte_class;

    typedef struct packed {
        logic [4:0]         code;
        logic               present;
        logic               valid;
        logic signed [31:0] value;
    } t_result;

    function automatic logic [7:0] verb_chr(int idx, logic [3:0] pos);
        int k;
        k = (int'(VERB_LEN[idx]) - 1 - int'(pos)) * 8;
        if (pos >= VERB_LEN[idx]) begin
            return 8'h00;
        end
        return VERB_TEXT[idx][k +: 8];
    endfunction

    function automatic logic [NUM_VERBS-1:0] verb_step(logic [NUM_VERBS-1:0] mask,
                                                       logic [3:0] pos, logic [7:0] lc);
        logic [NUM_VERBS-1:0] m;
        m = mask;
        for (int i = 0; i < NUM_VERBS; i++) begin
            if (pos >= VERB_LEN[i] || verb_chr(i, pos) != lc) begin
                m[i] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [NUM_VERBS-1:0] verb_close(logic [NUM_VERBS-1:0] mask,
                                                        logic [3:0] pos);
        logic [NUM_VERBS-1:0] m;
        m = mask;
        for (int i = 0; i < NUM_VERBS; i++) begin
            if (VERB_LEN[i] != pos) begin
                m[i] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [4:0] verb_pick(logic [NUM_VERBS-1:0] mask);
        logic [4:0] code;
        code = CODE_UNKNOWN;
        for (int i = NUM_VERBS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                code = VERB_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/ccl_front.sv
// ----------------------------------------------------------------------------
// ccl_front
// Input side: takes line bytes and classifies them for the parser queue.
// ----------------------------------------------------------------------------
module ccl_front (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output ccl_pkg::t_byte_class o_class
);
    import ccl_pkg::*;

    always_comb begin
        o_class.lc       = (i_byte >= "A" && i_byte <= "Z") ? i_byte + 8'd32 : i_byte;
        o_class.is_end   = (i_byte == 8'h00);
        o_class.is_ws    = (i_byte == " ") || (i_byte == 8'h09) ||
                           (i_byte == 8'h0D) || (i_byte == 8'h0A);
        o_class.is_digit = (i_byte >= "0") && (i_byte <= "9");
        o_class.is_plus  = (i_byte == "+");
        o_class.is_minus = (i_byte == "-");
        o_class.digit    = i_byte[3:0];
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// File: rtl/ccl_fifo.sv
// ----------------------------------------------------------------------------
// ccl_fifo
// Short queue between the classifier and the parser state machine.
// ----------------------------------------------------------------------------
module ccl_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [Width-1:0] o_data
);
    import ccl_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// File: rtl/ccl_parse.sv
// ----------------------------------------------------------------------------
// ccl_parse
// Parser state machine: matches the verb, accumulates the argument and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
module ccl_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ccl_pkg::t_byte_class i_class,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ccl_pkg::t_result     o_result
);
    import ccl_pkg::*;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_VERB   = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;

    localparam logic [3:0]  POS_MAX = 4'd15;
    localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIM = 32'h8000_0000;

    logic [2:0]           r_phase,   n_phase;
    logic [NUM_VERBS-1:0] r_mask,    n_mask;
    logic [3:0]           r_pos,     n_pos;
    logic                 r_neg,     n_neg;
    logic [31:0]          r_mag,     n_mag;
    logic                 r_rej,     n_rej;
    logic                 r_started, n_started;
    logic                 r_out_valid, n_out_valid;
    t_result              r_result,  n_result;

    logic                 w_out_free;
    logic [35:0]          w_sum;
    logic                 w_add;
    logic [NUM_VERBS-1:0] w_end_mask;
    logic                 w_num_phase;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = i_valid && (!i_class.is_end || w_out_free);
    assign w_sum      = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {32'b0, i_class.digit};
    assign w_end_mask = (r_phase == PH_VERB) ? verb_close(r_mask, r_pos) : r_mask;
    assign w_num_phase = (r_phase == PH_DIGITS) || (r_phase == PH_TRAIL);

    always_comb begin
        n_phase     = r_phase;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rej       = r_rej;
        n_started   = r_started;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_ready;
        w_add       = 1'b0;

        if (o_pop && i_class.is_end) begin
            n_result = '{code: CODE_NONE, present: 1'b0, valid: 1'b0, value: 32'sd0};
            if (r_phase != PH_LEAD) begin
                n_result.code    = verb_pick(w_end_mask);
                n_result.present = r_started;
                if (r_started && !r_rej && w_num_phase) begin
                    if (r_neg) begin
                        if (r_mag <= NEG_LIM) begin
                            n_result.valid = 1'b1;
                            n_result.value = -$signed(r_mag);
                        end
                    end else if (r_mag <= POS_LIM) begin
                        n_result.valid = 1'b1;
                        n_result.value = $signed(r_mag);
                    end
                end
            end
            n_out_valid = 1'b1;
            n_phase     = PH_LEAD;
            n_mask      = ALL_VERBS;
            n_pos       = '0;
            n_neg       = 1'b0;
            n_mag       = '0;
            n_rej       = 1'b0;
            n_started   = 1'b0;
        end else if (o_pop) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!i_class.is_ws) begin
                        n_phase = PH_VERB;
                        n_mask  = verb_step(ALL_VERBS, 4'd0, i_class.lc);
                        n_pos   = 4'd1;
                    end
                end
                PH_VERB: begin
                    if (i_class.is_ws) begin
                        n_mask  = verb_close(r_mask, r_pos);
                        n_phase = PH_GAP;
                    end else begin
                        n_mask = verb_step(r_mask, r_pos, i_class.lc);
                        n_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
                    end
                end
                PH_GAP: begin
                    if (!i_class.is_ws) begin
                        n_started = 1'b1;
                        if (i_class.is_plus || i_class.is_minus) begin
                            n_neg   = i_class.is_minus;
                            n_phase = PH_SIGN;
                        end else if (i_class.is_digit) begin
                            w_add   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_rej   = 1'b1;
                            n_phase = PH_TRAIL;
                        end
                    end
                end
                PH_SIGN: begin
                    if (i_class.is_digit) begin
                        w_add   = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_rej   = 1'b1;
                        n_phase = PH_TRAIL;
                    end
                end
                PH_DIGITS: begin
                    if (i_class.is_digit) begin
                        w_add = 1'b1;
                    end else if (i_class.is_ws) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_rej   = 1'b1;
                        n_phase = PH_TRAIL;
                    end
                end
                default: begin
                    if (!i_class.is_ws) begin
                        n_rej = 1'b1;
                    end
                    n_phase = PH_TRAIL;
                end
            endcase
            if (w_add) begin
                if (w_sum[35:32] != 4'b0) begin
                    n_rej = 1'b1;
                end else begin
                    n_mag = w_sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_mask      <= ALL_VERBS;
            r_pos       <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_rej       <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mask      <= n_mask;
            r_pos       <= n_pos;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_rej       <= n_rej;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// File: rtl/console_command_line_parser.sv
// ----------------------------------------------------------------------------
// console_command_line_parser
// A terminating byte is written into the queue, then into the parser's result
// register, before its result can be transferred. Throughput: one byte per
// cycle unless the queue is full; the parser updates its state once per byte.
// The result register frees in the cycle its transfer completes.
// Reset: synchronous, active low; clears the queue, the parser state and the
// result valid flag.
// ----------------------------------------------------------------------------
module console_command_line_parser #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] line_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] argument_value
    output logic [6:0]  o_m_tuser    // [4:0] command_code, [5] argument_present,
                                     // [6] argument_valid
);
    import ccl_pkg::*;

    `include "console_command_line_parser_assert.svh"

    t_byte_class w_front_class;
    t_byte_class w_queue_class;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_queue_valid;
    t_result     w_result;

    ccl_front u_front (
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_class (w_front_class)
    );

    ccl_fifo #(
        .Width ($bits(t_byte_class)),
        .Depth (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_class),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_class)
    );

    ccl_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_queue_valid),
        .i_class  (w_queue_class),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = w_result.value;
    assign o_m_tuser = {w_result.valid, w_result.present, w_result.code};

    `CCL_ASSERT_NOW(a_valid_present, o_m_tvalid && o_m_tuser[6], o_m_tuser[5], "no text")
    `CCL_ASSERT_NOW(a_invalid_zero, o_m_tvalid && !o_m_tuser[6], o_m_tdata == 32'd0, "value set")
    `CCL_ASSERT_NOW(a_empty_no_arg, o_m_tvalid && o_m_tuser[4:0] == CODE_NONE, !o_m_tuser[5], "text")
    `CCL_ASSERT_NEXT(a_pop_drains, w_pop && !w_push && w_full, !w_full, "queue still full")

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - console command line parser testbench
// Streams console lines into the parser one byte per transfer and keeps its
// own line parser in step with every accepted byte. Each result transfer is
// checked field by field against the oldest predicted command. Directed
// lines cover every verb, the argument limits and the malformed forms. A
// random mix of well-formed, broken and noise lines follows. Both sides
// idle at random, the sink holds off once for a long stretch, and the
// source once pauses until all predicted commands have come back.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        CODE_HELP = 5'd2, CODE_STATUS, CODE_GETCANSPEED, CODE_SETCANSPEED, CODE_GETFLOWPIN,
        CODE_SETFLOWPIN, CODE_GETMETRIC, CODE_SETMETRIC, CODE_GETK, CODE_SETK, CODE_RESTART,
        CODE_GETCAPTURE, CODE_SETCAPTURE, CODE_GETCANRESET, CODE_SETCANRESET,
        CODE_GETPULSEGUARD, CODE_SETPULSEGUARD, CODE_DEBUG
    } t_verb_code;

    typedef enum logic [2:0] {
        LEAD_WS, IN_VERB, VERB_GAP, ARG_SIGN, ARG_DIGITS, ARG_TAIL
    } t_line_phase;

    typedef struct {
        logic [7:0] b;
        bit         hold;
    } t_line_byte;

    localparam int VERB_COUNT = 19;
    localparam int TOTAL_BYTES = 1650;

    string verb_words [VERB_COUNT] = '{
        "help", "?", "status", "getcanspeed", "setcanspeed", "getflowpin",
        "setflowpin", "getmetric", "setmetric", "getk", "setk", "reset",
        "getcapture", "setcapture", "getcanreset", "setcanreset",
        "getpulseguard", "setpulseguard", "debug"
    };

    t_verb_code verb_cmds [VERB_COUNT] = '{
        CODE_HELP, CODE_HELP, CODE_STATUS, CODE_GETCANSPEED, CODE_SETCANSPEED,
        CODE_GETFLOWPIN, CODE_SETFLOWPIN, CODE_GETMETRIC, CODE_SETMETRIC, CODE_GETK,
        CODE_SETK, CODE_RESTART, CODE_GETCAPTURE, CODE_SETCAPTURE, CODE_GETCANRESET,
        CODE_SETCANRESET, CODE_GETPULSEGUARD, CODE_SETPULSEGUARD, CODE_DEBUG
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] line_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [31:0] argument_value
    logic [6:0]  m_tuser;             // [4:0] command_code, [5] argument_present,
                                      // [6] argument_valid
    logic        sink_hold = 1'b0;

    t_line_byte        pending_bytes [$];
    ccl_pkg::t_result  expected_cmds [$];
    int                bytes_accepted = 0;
    int                results_seen = 0;
    int                error_count = 0;

    t_line_phase  lp_phase = LEAD_WS;
    logic [18:0]  lp_hits = '1;
    logic [3:0]   lp_pos = 4'd0;
    logic         lp_neg = 1'b0;
    logic [31:0]  lp_mag = 32'd0;
    logic         lp_bad = 1'b0;
    logic         lp_seen = 1'b0;

    console_command_line_parser uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic match_verb_char(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int i = 0; i < VERB_COUNT; i++) begin
            if (lp_hits[i]) begin
                if (lp_pos >= verb_words[i].len() || verb_words[i][lp_pos] != lc) begin
                    lp_hits[i] = 1'b0;
                end
            end
        end
        if (lp_pos != 4'hF) begin
            lp_pos = lp_pos + 4'd1;
        end
    endtask

    task automatic close_verb();
        for (int i = 0; i < VERB_COUNT; i++) begin
            if (verb_words[i].len() != lp_pos) begin
                lp_hits[i] = 1'b0;
            end
        end
    endtask

    task automatic accumulate_digit(logic [7:0] c);
        logic [31:0] d;
        d = 32'(c - "0");
        if (lp_mag > (32'hFFFF_FFFF - d) / 32'd10) begin
            lp_bad = 1'b1;
        end else begin
            lp_mag = lp_mag * 32'd10 + d;
        end
    endtask

    task automatic parse_console_byte(logic [7:0] c);
        ccl_pkg::t_result cmd;
        bit found;
        if (c == 8'h00) begin
            cmd.code = ccl_pkg::CODE_NONE;
            cmd.present = 1'b0;
            cmd.valid = 1'b0;
            cmd.value = 32'sd0;
            if (lp_phase != LEAD_WS) begin
                if (lp_phase == IN_VERB) begin
                    close_verb();
                end
                cmd.code = ccl_pkg::CODE_UNKNOWN;
                found = 1'b0;
                for (int i = 0; i < VERB_COUNT; i++) begin
                    if (!found && lp_hits[i]) begin
                        cmd.code = verb_cmds[i];
                        found = 1'b1;
                    end
                end
                cmd.present = lp_seen;
                if (lp_seen && !lp_bad && (lp_phase == ARG_DIGITS || lp_phase == ARG_TAIL)) begin
                    if (lp_neg) begin
                        if (lp_mag <= 32'd2147483648) begin
                            cmd.valid = 1'b1;
                            cmd.value = 32'd0 - lp_mag;
                        end
                    end else if (lp_mag <= 32'd2147483647) begin
                        cmd.valid = 1'b1;
                        cmd.value = lp_mag;
                    end
                end
            end
            expected_cmds.push_back(cmd);
            lp_phase = LEAD_WS;
            lp_hits = '1;
            lp_pos = 4'd0;
            lp_neg = 1'b0;
            lp_mag = 32'd0;
            lp_bad = 1'b0;
            lp_seen = 1'b0;
        end else begin
            case (lp_phase)
                LEAD_WS: begin
                    if (!is_space(c)) begin
                        lp_phase = IN_VERB;
                        lp_hits = '1;
                        lp_pos = 4'd0;
                        match_verb_char(c);
                    end
                end
                IN_VERB: begin
                    if (is_space(c)) begin
                        close_verb();
                        lp_phase = VERB_GAP;
                    end else begin
                        match_verb_char(c);
                    end
                end
                VERB_GAP: begin
                    if (!is_space(c)) begin
                        lp_seen = 1'b1;
                        if (c == "+" || c == "-") begin
                            lp_neg = (c == "-");
                            lp_phase = ARG_SIGN;
                        end else if (is_num(c)) begin
                            accumulate_digit(c);
                            lp_phase = ARG_DIGITS;
                        end else begin
                            lp_bad = 1'b1;
                            lp_phase = ARG_TAIL;
                        end
                    end
                end
                ARG_SIGN: begin
                    if (is_num(c)) begin
                        accumulate_digit(c);
                        lp_phase = ARG_DIGITS;
                    end else begin
                        lp_bad = 1'b1;
                        lp_phase = ARG_TAIL;
                    end
                end
                ARG_DIGITS: begin
                    if (is_num(c)) begin
                        accumulate_digit(c);
                    end else if (is_space(c)) begin
                        lp_phase = ARG_TAIL;
                    end else begin
                        lp_bad = 1'b1;
                        lp_phase = ARG_TAIL;
                    end
                end
                default: begin
                    if (!is_space(c)) begin
                        lp_bad = 1'b1;
                    end
                    lp_phase = ARG_TAIL;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t tb_top mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    task automatic push_line(string s, bit hold);
        t_line_byte item;
        item.hold = hold;
        for (int k = 0; k < s.len(); k++) begin
            item.b = s[k];
            pending_bytes.push_back(item);
            item.hold = 1'b0;
        end
        item.b = 8'h00;
        pending_bytes.push_back(item);
    endtask

    task automatic push_noise();
        t_line_byte item;
        int n;
        n = $urandom_range(1, 12);
        item.hold = 1'b0;
        for (int k = 0; k < n; k++) begin
            item.b = 8'($urandom_range(0, 255));
            pending_bytes.push_back(item);
        end
        item.b = 8'h00;
        pending_bytes.push_back(item);
    endtask

    function automatic string rand_space(int lo, int hi);
        string ws;
        string s;
        int n;
        ws = " \t\r\n";
        s = "";
        n = $urandom_range(lo, hi);
        for (int k = 0; k < n; k++) begin
            s = {s, " "};
            s[s.len() - 1] = ws[$urandom_range(0, 3)];
        end
        return s;
    endfunction

    function automatic string rand_verb();
        string s;
        s = verb_words[$urandom_range(0, VERB_COUNT - 1)];
        for (int k = 0; k < s.len(); k++) begin
            if (s[k] >= "a" && s[k] <= "z" && $urandom_range(0, 1) == 1) begin
                s[k] = s[k] - 8'd32;
            end
        end
        return s;
    endfunction

    function automatic string rand_number();
        longint unsigned limits [6] = '{64'd0, 64'd2147483647, 64'd2147483648,
                                        64'd2147483649, 64'd4294967295, 64'd4294967296};
        string s;
        int n;
        case ($urandom_range(0, 5))
            0: s = $sformatf("%0d", $urandom_range(0, 999));
            1: s = $sformatf("%0d", $urandom);
            2: s = $sformatf("%0d", limits[$urandom_range(0, 5)]);
            3: begin
                n = $urandom_range(10, 14);
                s = "";
                for (int k = 0; k < n; k++) begin
                    s = {s, $sformatf("%0d", $urandom_range(0, 9))};
                end
            end
            default: s = $sformatf("%0d", $urandom_range(0, 99999));
        endcase
        return s;
    endfunction

    function automatic string rand_sign();
        case ($urandom_range(0, 3))
            0: return "+";
            1: return "-";
            default: return "";
        endcase
    endfunction

    function automatic string rand_command();
        string s;
        s = {rand_space(0, 2), rand_verb()};
        if ($urandom_range(0, 9) < 7) begin
            s = {s, rand_space(1, 2), rand_sign(), rand_number(), rand_space(0, 2)};
        end
        return s;
    endfunction

    function automatic string rand_broken();
        string s;
        string junk;
        int k;
        junk = " ";
        junk[0] = 8'($urandom_range(33, 126));
        case ($urandom_range(0, 3))
            0: s = {rand_verb(), rand_space(1, 2), rand_sign(), rand_space(0, 1)};
            1: s = {rand_verb(), rand_space(1, 2), rand_sign(), rand_number(), junk,
                    rand_number()};
            2: begin
                s = rand_command();
                k = $urandom_range(0, s.len());
                s = {s.substr(0, k - 1), junk, s.substr(k, s.len() - 1)};
            end
            default: begin
                s = rand_verb();
                s = {s.substr(0, s.len() - 2), rand_space(1, 1), rand_number()};
            end
        endcase
        return s;
    endfunction

    // source: offer the queued bytes, track accepted ones through the line parser
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_console_byte(s_tdata);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0
                        && !(pending_bytes[0].hold && expected_cmds.size() != 0)
                        && !((bytes_accepted < 700 || bytes_accepted >= 1000)
                             && $urandom_range(0, 99) < 12)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_bytes[0].b;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: check each result transfer against the oldest predicted command
    always @(posedge clk) begin : sink
        ccl_pkg::t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected command_code", m_tuser[4:0], -1);
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_tuser[4:0] !== want.code)
                        report_mismatch("command_code", m_tuser[4:0], want.code);
                    if (m_tuser[5] !== want.present)
                        report_mismatch("argument_present", m_tuser[5], want.present);
                    if (m_tuser[6] !== want.valid)
                        report_mismatch("argument_valid", m_tuser[6], want.valid);
                    if (m_tdata !== want.value)
                        report_mismatch("argument_value", longint'($signed(m_tdata)),
                                        longint'(want.value));
                end
            end
            m_tready <= !(sink_hold || ((results_seen < 80 || results_seen >= 110)
                                        && $urandom_range(0, 99) < 12));
        end
    end

    // hold the sink off long enough for the parser to back up into its input
    initial begin
        while (results_seen < 40) @(posedge clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin
        push_line("", 1'b0);
        push_line(" \t\r\n", 1'b0);
        push_line("help", 1'b0);
        push_line("?   ", 1'b0);
        push_line("STATUS 0", 1'b0);
        push_line("GetCanSpeed 2147483647", 1'b0);
        push_line("setcanspeed -2147483648", 1'b0);
        push_line("getflowpin 2147483648", 1'b0);
        push_line("SETFLOWPIN -2147483649", 1'b0);
        push_line("getmetric 4294967295", 1'b0);
        push_line("setmetric 4294967296", 1'b0);
        push_line("getk +", 1'b0);
        push_line("setK - 5", 1'b0);
        push_line("reset 12x", 1'b0);
        push_line("getcapture abc", 1'b0);
        push_line("setcapture +17 \t", 1'b0);
        push_line("getcanreset 5 6", 1'b0);
        push_line("setcanreset 0000000000042", 1'b0);
        push_line("getpulseguard 99999999999999", 1'b0);
        push_line("setpulseguard\t-0", 1'b0);
        push_line("\n  DeBuG  \r", 1'b0);
        push_line("getpulseguardextra", 1'b0);
        push_line("hel", 1'b0);
        push_line("helpx 1", 1'b0);
        push_line("frobnicate 7", 1'b0);
        push_line(rand_command(), 1'b1);
        while (pending_bytes.size() < TOTAL_BYTES) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  push_line(rand_broken(), 1'b0);
                3:        push_noise();
                default:  push_line(rand_command(), 1'b0);
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ccl_pkg.sv
rtl/ccl_front.sv
rtl/ccl_fifo.sv
rtl/ccl_parse.sv
rtl/console_command_line_parser.sv
tb/sv/tb_top.sv
